// File: hw/rtl/qru_pkg.sv
package qru_pkg;

  localparam int WORD_W        = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int SAT_IN_W      = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_W = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_X = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Z = 8'd3;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 18'sd131071;
  localparam logic signed [WORD_W-1:0] WORD_MIN = -18'sd131072;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_DIV_LD,
    ST_DIV,
    ST_PROD,
    ST_FIN
  } state_t;

  // Hamilton product r*p: term k of component c uses r[k] and p[c^k]
  function automatic logic hp_neg(input logic [1:0] c, input logic [1:0] k);
    logic n;
    n = 1'b0;
    unique case (c)
      2'd0: n = (k != 2'd0);
      2'd1: n = (k == 2'd3);
      2'd2: n = (k == 2'd1);
      2'd3: n = (k == 2'd2);
      default: n = 1'b0;
    endcase
    return n;
  endfunction

  function automatic word_t sat_word(input logic signed [SAT_IN_W-1:0] v);
    word_t r;
    if (v > SAT_IN_W'(WORD_MAX)) r = WORD_MAX;
    else if (v < SAT_IN_W'(WORD_MIN)) r = WORD_MIN;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/quaternion_rotation_update.sv
// Handles one request at a time. An apply request is normalized twice: squaring
//   passes, a bit-serial square root and the one-bit-per-cycle divider, run first on
//   the matrix quaternion and then on its Hamilton product with the pose. Load
//   requests and a radicand that is not positive go straight to the result; a zero
//   norm ends after its square root.
// Reset (rst, synchronous, active high): pose and init_w = one, others zero,
//   no output pending.
module quaternion_rotation_update
  import qru_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input request
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic signed [17:0]   m00,
  input  logic signed [17:0]   m01,
  input  logic signed [17:0]   m02,
  input  logic signed [17:0]   m10,
  input  logic signed [17:0]   m11,
  input  logic signed [17:0]   m12,
  input  logic signed [17:0]   m20,
  input  logic signed [17:0]   m21,
  input  logic signed [17:0]   m22,
  // result request
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [17:0]   pose_w,
  output logic signed [17:0]   pose_x,
  output logic signed [17:0]   pose_y,
  output logic signed [17:0]   pose_z,
  output logic                 degenerate,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic signed [17:0]   cfg_data
);

  // RW: vectors under normalization (radicand, differences, rounded product)
  localparam int RW  = ((FRAC_BITS > 20) ? FRAC_BITS : 20) + 2;
  localparam int NW  = RW + 1;            // norm width
  localparam int SSW = 2 * NW;            // sum of squares
  localparam int QW  = FRAC_BITS + 1;     // quotient never exceeds one
  localparam int AW  = RW + FRAC_BITS + 1; // rounded dividend
  localparam int PW  = 2 * RW + 2;        // product accumulator
  localparam int ITW = $clog2((NW > QW) ? NW : QW);
  localparam int OW  = FRAC_BITS + 2;     // normalized component

  localparam word_t ONE_SAT = (FRAC_BITS >= 17) ? WORD_MAX : WORD_W'(1 << FRAC_BITS);

  state_t state, state_next;

  word_t init_q [4];
  word_t pose_q [4];

  logic signed [RW-1:0] vec [4];  // vector being normalized
  logic signed [OW-1:0] rq  [4];  // normalized result
  logic [SSW-1:0]       ss;       // sum of squares, then sqrt remainder
  logic [SSW-1:0]       sq_res;
  logic [SSW-1:0]       sq_bit;
  logic [NW-1:0]        nrm;
  logic [NW:0]          rem;
  logic [QW-1:0]        dvd;
  logic [QW-1:0]        quo;
  logic                 dneg;
  logic signed [PW-1:0] acc;
  logic [1:0]           cnt_c;
  logic [2:0]           cnt_k;
  logic [ITW-1:0]       it;
  logic                 phase;    // 0: matrix quaternion, 1: product
  logic                 fin_load;
  logic                 fin_deg;

  logic in_acc, fin_go;
  assign in_acc = in_valid && !in_stall;
  assign fin_go = (state == ST_FIN) && !(out_valid && out_stall);

  // ---- matrix to scaled quaternion (Shepperd branch select) ----
  logic signed [RW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [RW-1:0] tr, rad, one_r;
  logic signed [RW-1:0] qin [4];
  assign e00 = RW'(m00);
  assign e01 = RW'(m01);
  assign e02 = RW'(m02);
  assign e10 = RW'(m10);
  assign e11 = RW'(m11);
  assign e12 = RW'(m12);
  assign e20 = RW'(m20);
  assign e21 = RW'(m21);
  assign e22 = RW'(m22);
  assign one_r = RW'(1) <<< FRAC_BITS;
  assign tr = e00 + e11 + e22;

  always_comb begin
    priority if (tr > 0) begin
      rad = tr + one_r;
      qin[0] = rad;       qin[1] = e21 - e12; qin[2] = e02 - e20; qin[3] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      rad = one_r + e00 - e11 - e22;
      qin[0] = e21 - e12; qin[1] = rad;       qin[2] = e01 + e10; qin[3] = e02 + e20;
    end else if (e11 > e22) begin
      rad = one_r + e11 - e00 - e22;
      qin[0] = e02 - e20; qin[1] = e01 + e10; qin[2] = rad;       qin[3] = e12 + e21;
    end else begin
      rad = one_r + e22 - e00 - e11;
      qin[0] = e10 - e01; qin[1] = e02 + e20; qin[2] = e12 + e21; qin[3] = rad;
    end
  end

  // ---- shared multiplier ----
  logic signed [RW-1:0]   mul_a, mul_b;
  logic signed [2*RW-1:0] prod;
  always_comb begin
    mul_a = vec[cnt_c];
    mul_b = vec[cnt_c];
    if (state == ST_PROD) begin
      mul_a = RW'(rq[cnt_k[1:0]]);
      mul_b = RW'(pose_q[cnt_c ^ cnt_k[1:0]]);
    end
  end
  assign prod = mul_a * mul_b;

  // ---- sqrt step ----
  logic [SSW-1:0] sq_try, sq_res_next, ss_sqrt_next;
  logic           sq_ge;
  assign sq_try       = sq_res + sq_bit;
  assign sq_ge        = ss >= sq_try;
  assign sq_res_next  = sq_ge ? (sq_res >> 1) + sq_bit : (sq_res >> 1);
  assign ss_sqrt_next = sq_ge ? ss - sq_try : ss;

  // ---- divide step ----
  logic [NW:0]          rem_sh, rem_next;
  logic                 dv_ge;
  logic [QW-1:0]        quo_next;
  logic signed [OW-1:0] dq;
  assign rem_sh   = {rem[NW-1:0], dvd[QW-1]};
  assign dv_ge    = rem_sh >= {1'b0, nrm};
  assign rem_next = dv_ge ? rem_sh - {1'b0, nrm} : rem_sh;
  assign quo_next = {quo[QW-2:0], dv_ge};
  assign dq       = dneg ? -$signed(OW'(quo_next)) : $signed(OW'(quo_next));

  // dividend |v| * one + n/2
  logic [RW-1:0] absv;
  logic [AW-1:0] dnum;
  assign absv = vec[cnt_c][RW-1] ? RW'(-vec[cnt_c]) : RW'(vec[cnt_c]);
  assign dnum = (AW'(absv) << FRAC_BITS) + AW'(nrm >> 1);

  // ---- product rounding back to FRAC_BITS ----
  logic signed [PW-1:0] acc_term;
  logic [PW-1:0]        acc_mag, acc_rnd;
  logic signed [RW-1:0] t_rnd;
  assign acc_term = hp_neg(cnt_c, cnt_k[1:0]) ? acc - PW'(prod) : acc + PW'(prod);
  assign acc_mag  = acc[PW-1] ? PW'(-acc) : PW'(acc);
  assign acc_rnd  = (acc_mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign t_rnd    = acc[PW-1] ? -$signed(RW'(acc_rnd)) : $signed(RW'(acc_rnd));

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (action || rad <= 0) state_next = ST_FIN;
          else state_next = ST_SQ;
        end
      end
      ST_SQ:   if (cnt_c == 2'd3) state_next = ST_SQRT;
      ST_SQRT: begin
        if (it == ITW'(NW - 1)) begin
          state_next = (sq_res_next == '0) ? ST_FIN : ST_DIV_LD;
        end
      end
      ST_DIV_LD: state_next = ST_DIV;
      ST_DIV: begin
        if (it == ITW'(QW - 1)) begin
          if (cnt_c != 2'd3) state_next = ST_DIV_LD;
          else state_next = phase ? ST_FIN : ST_PROD;
        end
      end
      ST_PROD: if (cnt_k == 3'd4 && cnt_c == 2'd3) state_next = ST_SQ;
      ST_FIN:  if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    cfg_ready = 1'b1;
  end

  // control state, pose, registers, output request
  word_t newp [4];
  always_comb begin
    for (int i = 0; i < 4; i++) newp[i] = sat_word(SAT_IN_W'(rq[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      init_q[0] <= ONE_SAT;
      init_q[1] <= '0;
      init_q[2] <= '0;
      init_q[3] <= '0;
      pose_q[0] <= ONE_SAT;
      pose_q[1] <= '0;
      pose_q[2] <= '0;
      pose_q[3] <= '0;
    end else begin
      state <= state_next;
      if (fin_go) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (fin_go) begin
        if (fin_load) begin
          for (int i = 0; i < 4; i++) pose_q[i] <= init_q[i];
        end else if (!fin_deg) begin
          for (int i = 0; i < 4; i++) pose_q[i] <= newp[i];
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_INIT_W: init_q[0] <= cfg_data;
          CFG_INIT_X: init_q[1] <= cfg_data;
          CFG_INIT_Y: init_q[2] <= cfg_data;
          CFG_INIT_Z: init_q[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (fin_go) begin
      degenerate <= fin_deg;
      priority if (fin_load) begin
        pose_w <= init_q[0]; pose_x <= init_q[1]; pose_y <= init_q[2]; pose_z <= init_q[3];
      end else if (fin_deg) begin
        pose_w <= pose_q[0]; pose_x <= pose_q[1]; pose_y <= pose_q[2]; pose_z <= pose_q[3];
      end else begin
        pose_w <= newp[0];   pose_x <= newp[1];   pose_y <= newp[2];   pose_z <= newp[3];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        fin_load <= action;
        fin_deg  <= !action;  // only reached FIN directly when rad <= 0
        phase    <= 1'b0;
        cnt_c    <= '0;
        ss       <= '0;
        for (int i = 0; i < 4; i++) vec[i] <= qin[i];
      end
      ST_SQ: begin
        ss     <= ss + SSW'(unsigned'(prod));
        cnt_c  <= cnt_c + 2'd1;
        sq_res <= '0;
        sq_bit <= SSW'(1) << (SSW - 2);
        it     <= '0;
      end
      ST_SQRT: begin
        ss     <= ss_sqrt_next;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        it     <= it + ITW'(1);
        nrm    <= sq_res_next[NW-1:0];
        cnt_c  <= '0;
        fin_deg <= 1'b1;  // zero norm exits straight to FIN
      end
      ST_DIV_LD: begin
        rem  <= (NW + 1)'(dnum[AW-1:QW]);
        dvd  <= dnum[QW-1:0];
        quo  <= '0;
        dneg <= vec[cnt_c][RW-1];
        it   <= '0;
      end
      ST_DIV: begin
        rem <= rem_next;
        dvd <= dvd << 1;
        quo <= quo_next;
        it  <= it + ITW'(1);
        fin_deg <= 1'b0;
        if (it == ITW'(QW - 1)) begin
          rq[cnt_c] <= dq;
          cnt_c     <= cnt_c + 2'd1;
          cnt_k     <= '0;
          acc       <= '0;
        end
      end
      ST_PROD: begin
        if (cnt_k == 3'd4) begin
          vec[cnt_c] <= t_rnd;
          acc        <= '0;
          cnt_k      <= '0;
          cnt_c      <= cnt_c + 2'd1;
          if (cnt_c == 2'd3) begin
            phase <= 1'b1;
            ss    <= '0;
          end
        end else begin
          acc   <= acc_term;
          cnt_k <= cnt_k + 3'd1;
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_div_rem_below_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < {1'b0, nrm}))
    else $error("divider remainder not below norm");

  a_div_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_LD) |-> (nrm != '0))
    else $error("division started with zero norm");

  a_deg_keeps_pose: assert property (@(posedge clk) disable iff (rst)
    (fin_go && fin_deg && !fin_load) |=>
      (pose_q[0] == $past(pose_q[0]) && pose_q[1] == $past(pose_q[1]) &&
       pose_q[2] == $past(pose_q[2]) && pose_q[3] == $past(pose_q[3])))
    else $error("degenerate request changed the pose");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pose_w) && $stable(degenerate)))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/quaternion_rotation_update_tb.sv
module quaternion_rotation_update_tb
  import qru_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd1 << FRAC_BITS_DEF;
  // index past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd9;
  localparam logic ACT_APPLY = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  typedef longint quad_t[4];

  typedef struct {
    logic  action;
    word_t m[9];   // row-major m00..m22
  } pose_req_t;

  typedef struct {
    word_t w, x, y, z;
    logic  deg;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  action = 1'b0;
  word_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
  word_t m12 = '0, m20 = '0, m21 = '0, m22 = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t pose_w, pose_x, pose_y, pose_z;
  logic  degenerate;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t cfg_data = '0;

  // requests waiting to go out, and pose results still owed by the block
  pose_req_t pending_reqs[$];
  pose_res_t pose_due[$];

  // predictor copy of the pose and the init registers
  longint pose_q[4];
  longint init_q[4];

  int  n_errors   = 0;
  int  n_accepted = 0;
  bit  req_taken  = 1'b0;
  bit  calm       = 1'b0;   // no idling on either side while set
  bit  hold_on    = 1'b0;   // long receiver hold-off
  int  send_gap   = 0;
  int  stall_left = 0;

  quaternion_rotation_update u_dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round to nearest, ties away from zero; b > 0
  function automatic longint round_div(longint a, longint b);
    longint unsigned mag, q;
    mag = (a < 0) ? longint'(-a) : a;
    q = (mag + longint'(b) / 2) / longint'(b);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // scale v to unit length in Q16; 0 when the norm is zero
  function automatic bit to_unit(input quad_t v, output quad_t o);
    longint unsigned ss, n, mag;
    ss = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (v[i] < 0) ? longint'(-v[i]) : v[i];
      ss += mag * mag;
    end
    n = floor_sqrt(ss);
    if (n == 0) return 1'b0;
    for (int i = 0; i < 4; i++) o[i] = round_div(v[i] * ONE, longint'(n));
    return 1'b1;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  function automatic pose_res_t pose_snapshot(logic deg);
    pose_res_t r;
    r.w = word_t'(pose_q[0]);
    r.x = word_t'(pose_q[1]);
    r.y = word_t'(pose_q[2]);
    r.z = word_t'(pose_q[3]);
    r.deg = deg;
    return r;
  endfunction

  // Shepperd conversion, left product with the pose, renormalize
  function automatic pose_res_t update_pose(pose_req_t req);
    longint a[9];
    longint tr, rad;
    quad_t q, r, t, o;
    if (req.action == ACT_LOAD) begin
      pose_q = init_q;
      return pose_snapshot(1'b0);
    end
    for (int i = 0; i < 9; i++) a[i] = req.m[i];
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      rad = tr + ONE;
      q = '{rad, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      rad = ONE + a[0] - a[4] - a[8];
      q = '{a[7] - a[5], rad, a[1] + a[3], a[2] + a[6]};
    end else if (a[4] > a[8]) begin
      rad = ONE + a[4] - a[0] - a[8];
      q = '{a[2] - a[6], a[1] + a[3], rad, a[5] + a[7]};
    end else begin
      rad = ONE + a[8] - a[0] - a[4];
      q = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], rad};
    end
    if (rad <= 0 || !to_unit(q, r)) return pose_snapshot(1'b1);
    t[0] = round_div(r[0]*pose_q[0] - r[1]*pose_q[1] - r[2]*pose_q[2] - r[3]*pose_q[3], ONE);
    t[1] = round_div(r[0]*pose_q[1] + r[1]*pose_q[0] + r[2]*pose_q[3] - r[3]*pose_q[2], ONE);
    t[2] = round_div(r[0]*pose_q[2] - r[1]*pose_q[3] + r[2]*pose_q[0] + r[3]*pose_q[1], ONE);
    t[3] = round_div(r[0]*pose_q[3] + r[1]*pose_q[2] - r[2]*pose_q[1] + r[3]*pose_q[0], ONE);
    if (!to_unit(t, o)) return pose_snapshot(1'b1);
    for (int i = 0; i < 4; i++) pose_q[i] = clamp_word(o[i]);
    return pose_snapshot(1'b0);
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // rotation matrix from a random quaternion, with a little noise
  function automatic pose_req_t rotation_req(int noise);
    pose_req_t req;
    longint w, x, y, z, s;
    longint v[9];
    do begin
      w = longint'($urandom_range(0, 65535)) - 32768;
      x = longint'($urandom_range(0, 65535)) - 32768;
      y = longint'($urandom_range(0, 65535)) - 32768;
      z = longint'($urandom_range(0, 65535)) - 32768;
      s = w*w + x*x + y*y + z*z;
    end while (s == 0);
    v[0] = s - 2*(y*y + z*z); v[1] = 2*(x*y - w*z); v[2] = 2*(x*z + w*y);
    v[3] = 2*(x*y + w*z); v[4] = s - 2*(x*x + z*z); v[5] = 2*(y*z - w*x);
    v[6] = 2*(x*z - w*y); v[7] = 2*(y*z + w*x); v[8] = s - 2*(x*x + y*y);
    req.action = ACT_APPLY;
    for (int i = 0; i < 9; i++)
      req.m[i] = word_t'(v[i] * ONE / s + longint'($urandom_range(0, 2*noise)) - noise);
    return req;
  endfunction

  function automatic pose_req_t diag_req(word_t d0, word_t d1, word_t d2);
    pose_req_t req;
    req.action = ACT_APPLY;
    foreach (req.m[i]) req.m[i] = '0;
    req.m[0] = d0; req.m[4] = d1; req.m[8] = d2;
    return req;
  endfunction

  function automatic pose_req_t fill_req(word_t v);
    pose_req_t req;
    req.action = ACT_APPLY;
    foreach (req.m[i]) req.m[i] = v;
    return req;
  endfunction

  function automatic pose_req_t load_req();
    pose_req_t req;
    req = fill_req(rand_word());   // matrix is ignored on load
    req.action = ACT_LOAD;
    return req;
  endfunction

  function automatic pose_req_t random_req();
    pose_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return load_req();
    if (pick < 60) return rotation_req($urandom_range(0, 1) ? 0 : 16);
    if (pick < 80) begin
      req.action = ACT_APPLY;
      foreach (req.m[i]) req.m[i] = rand_word();
      return req;
    end
    // near-rotation with one corrupted entry
    req = rotation_req(4);
    req.m[$urandom_range(0, 8)] = rand_word();
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && pose_due.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INIT_W: init_q[0] = data;
      CFG_INIT_X: init_q[1] = data;
      CFG_INIT_Y: init_q[2] = data;
      CFG_INIT_Z: init_q[3] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_init(word_t w, word_t x, word_t y, word_t z);
    write_reg(CFG_INIT_W, w);
    write_reg(CFG_INIT_X, x);
    write_reg(CFG_INIT_Y, y);
    write_reg(CFG_INIT_Z, z);
  endtask

  // ---------------------------------------------------------------------
  // request driver: holds a request until taken, then may idle a while
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic nv;
    nv = in_valid && !req_taken;
    if (req_taken) begin
      req_taken = 1'b0;
      send_gap = pick_gap();
    end
    if (!nv && !rst) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        nv = 1'b1;
        action <= pending_reqs[0].action;
        m00 <= pending_reqs[0].m[0]; m01 <= pending_reqs[0].m[1];
        m02 <= pending_reqs[0].m[2]; m10 <= pending_reqs[0].m[3];
        m11 <= pending_reqs[0].m[4]; m12 <= pending_reqs[0].m[5];
        m20 <= pending_reqs[0].m[6]; m21 <= pending_reqs[0].m[7];
        m22 <= pending_reqs[0].m[8];
      end
    end
    in_valid <= nv;
  end

  // result side back-pressure
  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (hold_on) begin
      st = 1'b1;
    end else if (!calm) begin
      if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if ($urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                 : $urandom_range(0, 3);
        st = 1'b1;
      end
    end
    out_stall <= st;
  end

  // ---------------------------------------------------------------------
  // monitor: predict on accepted requests, check accepted results
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pose_res_t exp_r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pose_due.push_back(update_pose(pending_reqs.pop_front()));
        req_taken = 1'b1;
        n_accepted++;
        if (n_accepted % 120 == 0) calm = !calm;
      end
      if (out_valid && !out_stall) begin
        if (pose_due.size() == 0) begin
          $error("unexpected result: pose_w %0d", pose_w);
          n_errors++;
        end else begin
          exp_r = pose_due.pop_front();
          if (pose_w !== exp_r.w) begin
            $error("pose_w: expected %0d, got %0d", exp_r.w, pose_w);
            n_errors++;
          end
          if (pose_x !== exp_r.x) begin
            $error("pose_x: expected %0d, got %0d", exp_r.x, pose_x);
            n_errors++;
          end
          if (pose_y !== exp_r.y) begin
            $error("pose_y: expected %0d, got %0d", exp_r.y, pose_y);
            n_errors++;
          end
          if (pose_z !== exp_r.z) begin
            $error("pose_z: expected %0d, got %0d", exp_r.z, pose_z);
            n_errors++;
          end
          if (degenerate !== exp_r.deg) begin
            $error("degenerate: expected %0d, got %0d", exp_r.deg, degenerate);
            n_errors++;
          end
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (n_accepted >= 200);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (1500) @(posedge clk);
    @(negedge clk);
    hold_on = 1'b0;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    pose_q = '{ONE, 0, 0, 0};
    init_q = '{ONE, 0, 0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset pose, each branch, field extremes
    pending_reqs.push_back(diag_req(word_t'(ONE), word_t'(ONE), word_t'(ONE)));
    pending_reqs.push_back(diag_req(word_t'(ONE), word_t'(-ONE), word_t'(-ONE)));
    pending_reqs.push_back(diag_req(word_t'(-ONE), word_t'(ONE), word_t'(-ONE)));
    pending_reqs.push_back(diag_req(word_t'(-ONE), word_t'(-ONE), word_t'(ONE)));
    pending_reqs.push_back(fill_req('0));                // trace zero, last branch
    pending_reqs.push_back(fill_req(WORD_MAX));
    pending_reqs.push_back(fill_req(WORD_MIN));
    pending_reqs.push_back(diag_req(WORD_MAX, WORD_MIN, WORD_MIN));
    pending_reqs.push_back(diag_req(WORD_MIN, WORD_MAX, WORD_MIN));
    pending_reqs.push_back(load_req());
    pending_reqs.push_back(rotation_req(0));
    pending_reqs.push_back(rotation_req(0));
    wait_idle();

    // zero init pose: product norm vanishes, pose kept
    write_init('0, '0, '0, '0);
    write_reg(CFG_UNUSED, WORD_MAX);
    pending_reqs.push_back(load_req());
    pending_reqs.push_back(rotation_req(0));
    pending_reqs.push_back(fill_req(WORD_MAX));
    wait_idle();

    // init values past unit range, used as written
    write_init(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    pending_reqs.push_back(load_req());
    pending_reqs.push_back(rotation_req(0));
    pending_reqs.push_back(diag_req(WORD_MAX, WORD_MAX, WORD_MIN));
    pending_reqs.push_back(load_req());
    pending_reqs.push_back(fill_req(WORD_MIN));
    wait_idle();

    // random phases, each under its own init pose
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_init(word_t'(ONE), '0, '0, '0);
        1: write_init(word_t'(-ONE), word_t'(ONE), word_t'(-ONE), word_t'(ONE));
        2: write_init(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        default: write_init(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      pending_reqs.push_back(load_req());
      for (int i = 0; i < 148; i++) pending_reqs.push_back(random_req());
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (n_errors == 0 && pose_due.size() == 0) begin
      $display("PASS quaternion_rotation_update");
    end else begin
      $display("FAIL quaternion_rotation_update");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL quaternion_rotation_update");
    $finish;
  end

endmodule
